@@ rtl/swmm_pkg.sv @@
package swmm_pkg;

    localparam int IN_TDATA_W  = 32;
    localparam int MEAN_W      = 32;
    localparam int MIN_W       = 32;
    localparam int MAX_W       = 32;
    localparam int FILL_W      = 5;
    localparam int OUT_FIELD_W = MEAN_W + MIN_W + MAX_W + FILL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ rtl/swmm_cell.sv @@
module swmm_cell #(
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_valid,
    output logic [DATA_W-1:0] o_data,
    output logic              o_valid
);

    logic [DATA_W-1:0] r_data;
    logic              r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

@@ rtl/swmm_div.sv @@
module swmm_div #(
    parameter int DVD_W = 37,
    parameter int DVS_W = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DVD_W-1:0]    i_dividend,
    input  logic [DVS_W-1:0]    i_divisor,
    output swmm_pkg::t_div_stat o_stat,
    output logic [DVD_W-1:0]    o_quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [DVS_W:0]    w_trial;
    logic [DVS_W:0]    w_diff;
    logic              w_qbit;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

@@ rtl/sliding_window_mean_min_max.sv @@
// Channel   Dir  Fields in tdata (lowest bit up)
// s_axis    in   sample[31:0]
// m_axis    out  window_mean[31:0], window_min[63:32], window_max[95:64],
//                fill_count[100:96], zero pad [103:101]
//
// Each item goes through a bit-serial divider that forms the mean, while the
// cell chain rotates once in parallel to find the minimum and maximum.
// The result sits in an output register, so the next sample is taken as soon
// as the engine is free while the result waits on m_axis_tready.
// Reset is synchronous, active low, and empties the window.
module sliding_window_mean_min_max #(
    parameter int WINDOW      = 20,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [swmm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // sample
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [swmm_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // mean, min, max, fill_count
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;

    swmm_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]                 r_count;
    logic [SUM_W-1:0]                 r_sum;
    logic [CNT_W-1:0]                 r_scan_cnt;
    logic [SAMPLE_BITS-1:0]           r_min;
    logic [SAMPLE_BITS-1:0]           r_max;
    logic                             r_m_valid;
    logic [swmm_pkg::OUT_TDATA_W-1:0] r_m_data;

    logic [SAMPLE_BITS-1:0] w_data [WINDOW];
    logic                   w_valid [WINDOW];
    logic [SAMPLE_BITS-1:0] w_head_data;
    logic                   w_head_valid;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic [SAMPLE_BITS-1:0] w_tail;
    logic                   w_tail_valid;
    logic                   w_accept;
    logic                   w_rotate;
    logic                   w_shift;
    logic                   w_div_start;
    logic                   w_out_free;
    logic [SUM_W-1:0]       w_quo;
    swmm_pkg::t_div_stat    w_div_stat;

    assign w_sample     = SAMPLE_BITS'(s_axis_tdata);
    assign w_tail       = w_data[WINDOW-1];
    assign w_tail_valid = w_valid[WINDOW-1];

    assign s_axis_tready = (r_state == swmm_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_rotate      = (r_state == swmm_pkg::S_RUN) && (r_scan_cnt != CNT_W'(WINDOW));
    assign w_shift       = w_accept || w_rotate;
    assign w_head_data   = w_accept ? w_sample : w_tail;
    assign w_head_valid  = w_accept ? 1'b1 : w_tail_valid;
    assign w_div_start   = (r_state == swmm_pkg::S_RUN) && (r_scan_cnt == '0)
                           && !w_div_stat.busy;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    genvar k;
    generate
        for (k = 0; k < WINDOW; k++) begin : g_cell
            if (k == 0) begin : g_head
                swmm_cell #(.DATA_W(SAMPLE_BITS)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_data  (w_head_data),
                    .i_valid (w_head_valid),
                    .o_data  (w_data[k]),
                    .o_valid (w_valid[k])
                );
            end else begin : g_body
                swmm_cell #(.DATA_W(SAMPLE_BITS)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_data  (w_data[k-1]),
                    .i_valid (w_valid[k-1]),
                    .o_data  (w_data[k]),
                    .o_valid (w_valid[k])
                );
            end
        end
    endgenerate

    swmm_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            swmm_pkg::S_IDLE: begin
                if (w_accept) n_state = swmm_pkg::S_RUN;
            end
            swmm_pkg::S_RUN: begin
                if (r_scan_cnt == CNT_W'(WINDOW) && w_div_stat.done)
                    n_state = swmm_pkg::S_DONE;
            end
            swmm_pkg::S_DONE: begin
                if (w_out_free) n_state = swmm_pkg::S_IDLE;
            end
            default: n_state = swmm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= swmm_pkg::S_IDLE;
            r_count   <= '0;
            r_sum     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                // drop the oldest sample once the window is full
                r_sum <= r_sum + SUM_W'(w_sample)
                         - (w_tail_valid ? SUM_W'(w_tail) : SUM_W'(0));
                if (r_count != CNT_W'(WINDOW)) r_count <= r_count + CNT_W'(1);
            end
            if (r_state == swmm_pkg::S_DONE && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_scan_cnt <= '0;
            r_min      <= '1;
            r_max      <= '0;
        end else if (w_rotate) begin
            r_scan_cnt <= r_scan_cnt + CNT_W'(1);
            if (w_tail_valid) begin
                if (w_tail < r_min) r_min <= w_tail;
                if (w_tail > r_max) r_max <= w_tail;
            end
        end
        if (r_state == swmm_pkg::S_DONE && w_out_free) begin
            r_m_data <= {{swmm_pkg::OUT_PAD_W{1'b0}},
                         swmm_pkg::FILL_W'(r_count),
                         swmm_pkg::MAX_W'(r_max),
                         swmm_pkg::MIN_W'(r_min),
                         swmm_pkg::MEAN_W'(w_quo)};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

@@ rtl/swmm_checker.sv @@
module swmm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [swmm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [31:0] w_mean;
    logic [31:0] w_min;
    logic [31:0] w_max;
    logic [4:0]  w_fill;

    assign w_mean = m_axis_tdata[31:0];
    assign w_min  = m_axis_tdata[63:32];
    assign w_max  = m_axis_tdata[95:64];
    assign w_fill = m_axis_tdata[100:96];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_fill != 5'd0)
        else $error("result with empty window");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_min <= w_max)
        else $error("window min above max");

    a_mean_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_mean >= w_min) && (w_mean <= w_max))
        else $error("mean outside min..max");

    a_input_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("engine took a second sample while busy");

endmodule

bind sliding_window_mean_min_max swmm_checker u_swmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
